// ===== design/bmf_pkg.sv =====
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants, register indexes and the command struct that passes
// from the controller to the datapath of the block median filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

   localparam int SAMPLES      = 10;
   localparam int SAMPLE_WIDTH = 24;
   localparam int MEDIAN_POS   = (SAMPLES + 1) / 2;
   localparam int CNT_W        = $clog2(SAMPLES);
   localparam int SUM_W        = SAMPLE_WIDTH + $clog2(SAMPLES);
   localparam int MAG_W        = SUM_W - 1;
   localparam int RECIP_SHIFT  = MAG_W + $clog2(SAMPLES);
   localparam int RECIP_W      = SUM_W;
   localparam int PROD_W       = MAG_W + RECIP_W;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = SAMPLE_WIDTH;

   localparam logic [RECIP_W-1:0] RECIP_MULT =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   localparam logic [CSR_INDEX_W-1:0] REG_FILTER_MODE   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BASE_ALTITUDE = 1'd1;

   localparam logic MODE_MEDIAN = 1'b0;
   localparam logic MODE_MEAN   = 1'b1;

   typedef struct packed {
      logic             load_diff;
      logic             insert;
      logic [CNT_W-1:0] fill;
      logic             div_start;
      logic             div_step;
      logic             load_result;
      logic             use_mean;
   } dp_cmd_type;

endpackage

// ===== design/bmf_datapath.sv =====
// ----------------------------------------------------------------------------
// bmf_datapath
// Baseline subtraction with saturation, a row of sorted insertion cells,
// the running block sum, a reciprocal multiplier for the mean and the result
// register.
// ----------------------------------------------------------------------------
module bmf_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bmf_pkg::dp_cmd_type                    cmd,
   input  logic                                   csr_we,
   input  logic [bmf_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]         csr_wdata,
   input  logic signed [bmf_pkg::SAMPLE_WIDTH-1:0] sample,
   output logic signed [bmf_pkg::SAMPLE_WIDTH-1:0] result
);
   import bmf_pkg::*;

   localparam int EXT_W = SAMPLE_WIDTH + 1;

   logic signed [SAMPLE_WIDTH-1:0] base_ff;
   logic signed [SAMPLE_WIDTH-1:0] diff_ff, diff_in;
   logic signed [SAMPLE_WIDTH-1:0] cell_ff [SAMPLES];
   logic signed [SAMPLE_WIDTH-1:0] cell_in [SAMPLES];
   logic                           gt [SAMPLES];
   logic signed [SUM_W-1:0]        sum_ff, sum_in;
   logic [MAG_W-1:0]               mag_ff, mag_in;
   logic [SAMPLE_WIDTH-1:0]        quo_ff, quo_in;
   logic                           neg_ff, neg_in;
   logic signed [SAMPLE_WIDTH-1:0] result_ff, result_in;
   logic signed [EXT_W-1:0]        wide_diff;
   logic [SUM_W-1:0]               neg_sum;
   logic [PROD_W-1:0]              product;
   logic [SAMPLE_WIDTH-1:0]        signed_quo;

   always_comb begin
      wide_diff = {sample[SAMPLE_WIDTH-1], sample} - {base_ff[SAMPLE_WIDTH-1], base_ff};
      if (wide_diff[EXT_W-1] != wide_diff[EXT_W-2]) begin
         diff_in = wide_diff[EXT_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                      : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end else begin
         diff_in = wide_diff[SAMPLE_WIDTH-1:0];
      end
   end

   // Empty cells count as larger than any sample, so the compare row stays monotone.
   always_comb begin
      for (int i = 0; i < SAMPLES; i++) begin
         gt[i] = (CNT_W'(i) >= cmd.fill) || (cell_ff[i] > diff_ff);
      end
      for (int i = 0; i < SAMPLES; i++) begin
         if (!gt[i]) begin
            cell_in[i] = cell_ff[i];
         end else if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
         end else begin
            cell_in[i] = diff_ff;
         end
      end
   end

   always_comb begin
      sum_in = sum_ff;
      if (cmd.load_result) begin
         sum_in = '0;
      end else if (cmd.insert) begin
         sum_in = sum_ff + {{(SUM_W-SAMPLE_WIDTH){diff_ff[SAMPLE_WIDTH-1]}}, diff_ff};
      end
   end

   // The magnitude of the sum is multiplied by the rounded-up reciprocal of the
   // block length, which gives the exact truncated quotient over its range.
   always_comb begin
      neg_sum = SUM_W'(-sum_ff);
      product = PROD_W'(mag_ff) * PROD_W'(RECIP_MULT);
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      if (cmd.div_start) begin
         neg_in = sum_ff[SUM_W-1];
         mag_in = sum_ff[SUM_W-1] ? neg_sum[MAG_W-1:0] : sum_ff[MAG_W-1:0];
      end else if (cmd.div_step) begin
         quo_in = product[PROD_W-1:RECIP_SHIFT];
      end
   end

   always_comb begin
      signed_quo = neg_ff ? (~quo_ff + SAMPLE_WIDTH'(1)) : quo_ff;
      result_in  = result_ff;
      if (cmd.load_result) begin
         result_in = cmd.use_mean ? signed_quo : cell_ff[MEDIAN_POS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         sum_ff  <= '0;
      end else begin
         if (csr_we && csr_index == REG_BASE_ALTITUDE) begin
            base_ff <= csr_wdata;
         end
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_diff) begin
         diff_ff <= diff_in;
      end
      if (cmd.insert) begin
         for (int i = 0; i < SAMPLES; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
      mag_ff    <= mag_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== design/bmf_controller.sv =====
// ----------------------------------------------------------------------------
// bmf_controller
// Sequencer for the block median filter: input handshake, fill count,
// divider steps, mode register and the result valid flag.
// ----------------------------------------------------------------------------
module bmf_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic [bmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output bmf_pkg::dp_cmd_type             cmd
);
   import bmf_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_WRAP,
      S_DIVIDE,
      S_EMIT
   } state_type;

   state_type         state_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic              mode_ff;
   logic              pick_mean_ff;
   logic              rsp_valid_ff;
   logic              out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.fill        = fill_ff;
      cmd.use_mean    = pick_mean_ff;
      cmd.load_diff   = (state_ff == S_IDLE) && req_tvalid;
      cmd.insert      = (state_ff == S_INSERT);
      cmd.div_start   = (state_ff == S_WRAP) && (pick_mean_ff == MODE_MEAN);
      cmd.div_step    = (state_ff == S_DIVIDE);
      cmd.load_result = (state_ff == S_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         mode_ff      <= MODE_MEDIAN;
         pick_mean_ff <= MODE_MEDIAN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == REG_FILTER_MODE) begin
            mode_ff <= csr_wdata[0];
         end
         if (state_ff == S_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_INSERT;
               end
            end
            S_INSERT: begin
               if (fill_ff == CNT_W'(SAMPLES - 1)) begin
                  fill_ff      <= '0;
                  pick_mean_ff <= mode_ff;
                  state_ff     <= S_WRAP;
               end else begin
                  fill_ff  <= fill_ff + CNT_W'(1);
                  state_ff <= S_IDLE;
               end
            end
            S_WRAP: begin
               state_ff <= (pick_mean_ff == MODE_MEAN) ? S_DIVIDE : S_EMIT;
            end
            S_DIVIDE: begin
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== design/block_median_filter.sv =====
// ----------------------------------------------------------------------------
// block_median_filter
// Top level: baseline-relative altitude samples are collected in blocks and
// each full block yields its upper median or its truncated mean.
// ----------------------------------------------------------------------------
// Each sample beat is first subtracted and saturated, then inserted into the
// sorted cell row and the running sum. Every tenth beat completes a block;
// after that insertion a median result passes the WRAP and EMIT states, a
// mean result also the DIVIDE state between them, as the block sum passes
// through the reciprocal multiplier. The input is not taken while a block is
// being finished, but it is taken while a result beat waits on the output.
module block_median_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [23:0]                     req_tdata,  // altitude_sample[23:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,  // filtered_value[23:0]
   input  logic                            csr_we,
   input  logic [bmf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bmf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bmf_pkg::*;

   dp_cmd_type                     cmd;
   logic signed [SAMPLE_WIDTH-1:0] result;

   bmf_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd)
   );

   bmf_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sample    (req_tdata),
      .result    (result)
   );

   assign rsp_tdata = result;

endmodule

// ===== design/bmf_checker.sv =====
// ----------------------------------------------------------------------------
// bmf_checker
// Port-level checks on the block median filter, bound to the top level.
// ----------------------------------------------------------------------------
module bmf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // Every sample beat is followed by an insertion cycle with the input closed.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result beat changed or dropped");

endmodule

bind block_median_filter bmf_checker u_bmf_checker (.*);
